FILE: hdl/llca_pkg.sv
// llca_pkg: shared types, codes and the gamma table builder for the color adjust block
`default_nettype none

package llca_pkg;

  // adjustment modes
  localparam logic [2:0] MODE_LIGHTEN     = 3'd0;
  localparam logic [2:0] MODE_DARKEN      = 3'd1;
  localparam logic [2:0] MODE_SATURATE    = 3'd2;
  localparam logic [2:0] MODE_DESATURATE  = 3'd3;
  localparam logic [2:0] MODE_INTERPOLATE = 3'd4;
  // first unused mode code, pixel passes unchanged
  localparam logic [2:0] MODE_BYPASS      = 3'd5;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 17;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE         = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_AMOUNT       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LERP         = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_RED   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_GREEN = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_BLUE  = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_ALPHA = 3'd6;

  // interpolation fraction full scale
  localparam logic [16:0] LERP_ONE   = 17'd65536;
  localparam int          LERP_SHIFT = 16;

  // signed multiplier factor width, covers 1+amount and the lerp fraction
  localparam int FAC_BITS = 18;

  // encoder resolves two code bits per stage
  localparam int ENC_STAGES = 4;

  // front stages (lookup, sum, reciprocal products, mean), arithmetic, encoder
  localparam int LATENCY = 4 + 3 + ENC_STAGES;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] amount;
    logic [16:0]        lerp_fraction;
    logic [7:0]         target_red;
    logic [7:0]         target_green;
    logic [7:0]         target_blue;
    logic [7:0]         target_alpha;
  } cfg_t;

  // largest v in [0, lmax] with (2v-1)^5 * 255^11 <= 32 * lmax^5 * k^11,
  // i.e. round(lmax * (k/255)^2.2) with ties up, evaluated at elaboration
  function automatic logic [63:0] lin_entry(input int k, input int bits);
    logic [319:0] den;
    logic [319:0] rhs;
    logic [319:0] lhs;
    logic [63:0]  lmax;
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [63:0]  mid;
    lmax = (64'd1 << bits) - 64'd1;
    den = 320'd1;
    for (int i = 0; i < 11; i++) den = den * 320'd255;
    rhs = 320'd32;
    for (int i = 0; i < 5; i++) rhs = rhs * {256'd0, lmax};
    for (int i = 0; i < 11; i++) rhs = rhs * 320'(k);
    lo = 64'd0;
    hi = lmax;
    for (int n = 0; n < 40; n++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        lhs = den;
        for (int i = 0; i < 5; i++) lhs = lhs * {256'd0, (mid << 1) - 64'd1};
        if (lhs <= rhs) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/llca_channel.sv
// llca_channel: three-stage linear-light arithmetic for one channel
`default_nettype none

module llca_channel
  import llca_pkg::*;
#(
  parameter int LINEAR_BITS      = 24,
  parameter int AMOUNT_FRAC_BITS = 12
) (
  input  logic                   clk,
  input  logic                   advance,
  input  cfg_t                   cfg,
  input  logic [LINEAR_BITS-1:0] lin,
  input  logic [LINEAR_BITS-1:0] avg,
  input  logic [LINEAR_BITS-1:0] tgt,
  output logic [LINEAR_BITS-1:0] result
);

  localparam int DW = LINEAR_BITS + 1;
  localparam int PW = DW + FAC_BITS;
  localparam int SW = PW + 1;
  localparam logic signed [FAC_BITS-1:0] AMT_ONE = FAC_BITS'(1) << AMOUNT_FRAC_BITS;
  localparam logic signed [SW-1:0] LMAX_S = {{(SW-LINEAR_BITS){1'b0}}, {LINEAR_BITS{1'b1}}};

  logic signed [FAC_BITS-1:0] amt;
  logic signed [DW-1:0]       lin_s;
  logic signed [DW-1:0]       avg_s;
  logic signed [DW-1:0]       tgt_s;
  logic [LINEAR_BITS-1:0]     base_next;
  logic signed [DW-1:0]       diff_next;
  logic signed [FAC_BITS-1:0] fac_next;
  logic                       lerp_next;

  logic [LINEAR_BITS-1:0]     base_q;
  logic signed [DW-1:0]       diff_q;
  logic signed [FAC_BITS-1:0] fac_q;
  logic                       lerp_q;

  logic [LINEAR_BITS-1:0]     base_p;
  logic signed [PW-1:0]       prod;
  logic                       lerp_p;

  logic signed [PW-1:0]       shifted;
  logic signed [SW-1:0]       sum;
  logic [LINEAR_BITS-1:0]     result_next;

  // operand selection per mode
  always_comb begin
    amt = {{(FAC_BITS-16){cfg.amount[15]}}, cfg.amount};
    lin_s = signed'({1'b0, lin});
    avg_s = signed'({1'b0, avg});
    tgt_s = signed'({1'b0, tgt});
    base_next = lin;
    diff_next = '0;
    fac_next = '0;
    lerp_next = 1'b0;
    case (cfg.mode)
      MODE_LIGHTEN: begin
        base_next = '0;
        diff_next = lin_s;
        fac_next = AMT_ONE + amt;
      end
      MODE_DARKEN: begin
        base_next = '0;
        diff_next = lin_s;
        fac_next = AMT_ONE - amt;
      end
      MODE_SATURATE: begin
        diff_next = lin_s - avg_s;
        fac_next = amt;
      end
      MODE_DESATURATE: begin
        diff_next = lin_s - avg_s;
        fac_next = -amt;
      end
      MODE_INTERPOLATE: begin
        diff_next = tgt_s - lin_s;
        fac_next = signed'({1'b0, cfg.lerp_fraction});
        lerp_next = 1'b1;
      end
      default: begin
        // unused modes keep the value: zero factor
      end
    endcase
  end

  // floor shift, add base, clamp to zero and full scale
  always_comb begin
    shifted = lerp_p ? (prod >>> LERP_SHIFT) : (prod >>> AMOUNT_FRAC_BITS);
    sum = SW'(signed'({1'b0, base_p})) + SW'(shifted);
    if (sum[SW-1]) begin
      result_next = '0;
    end else if (sum > LMAX_S) begin
      result_next = {LINEAR_BITS{1'b1}};
    end else begin
      result_next = sum[LINEAR_BITS-1:0];
    end
  end

  // operand, product and result stages
  always_ff @(posedge clk) begin
    if (advance) begin
      base_q <= base_next;
      diff_q <= diff_next;
      fac_q <= fac_next;
      lerp_q <= lerp_next;
      base_p <= base_q;
      prod <= PW'(diff_q) * PW'(fac_q);
      lerp_p <= lerp_q;
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/llca_encode.sv
// llca_encode: pipelined binary search of a linear value back to an 8-bit code
`default_nettype none

module llca_encode
  import llca_pkg::*;
#(
  parameter int LINEAR_BITS = 24
) (
  input  logic                   clk,
  input  logic                   advance,
  input  logic [LINEAR_BITS-1:0] lin_tab [256],
  input  logic [LINEAR_BITS-1:0] value,
  output logic [7:0]             code
);

  logic [LINEAR_BITS-1:0] vin      [ENC_STAGES];
  logic [7:0]             iin      [ENC_STAGES];
  logic [7:0]             hi_try   [ENC_STAGES];
  logic [7:0]             mid_idx  [ENC_STAGES];
  logic [7:0]             lo_try   [ENC_STAGES];
  logic [7:0]             idx_next [ENC_STAGES];
  logic [LINEAR_BITS-1:0] val_q    [ENC_STAGES-1];
  logic [7:0]             idx_q    [ENC_STAGES];

  // each stage settles two code bits, table is nondecreasing with entry zero at zero
  always_comb begin
    vin[0] = value;
    iin[0] = '0;
    for (int st = 1; st < ENC_STAGES; st++) begin
      vin[st] = val_q[st-1];
      iin[st] = idx_q[st-1];
    end
    for (int st = 0; st < ENC_STAGES; st++) begin
      hi_try[st] = iin[st] | (8'd1 << (7 - 2 * st));
      mid_idx[st] = (lin_tab[hi_try[st]] <= vin[st]) ? hi_try[st] : iin[st];
      lo_try[st] = mid_idx[st] | (8'd1 << (6 - 2 * st));
      idx_next[st] = (lin_tab[lo_try[st]] <= vin[st]) ? lo_try[st] : mid_idx[st];
    end
  end

  // search stage registers
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int st = 0; st < ENC_STAGES - 1; st++) val_q[st] <= vin[st];
      for (int st = 0; st < ENC_STAGES; st++) idx_q[st] <= idx_next[st];
    end
  end

  assign code = idx_q[ENC_STAGES-1];

endmodule

`default_nettype wire

FILE: hdl/linear_light_color_adjust.sv
// linear_light_color_adjust: gamma 2.2 linear-light RGBA pixel adjustment pipeline
// Throughput: one pixel per clock; a stalled output beat freezes all stages,
// so in_stall follows out_stall while the last stage holds a beat.
// Reset (rst, synchronous) clears the stage valid bits and all config registers.
`default_nettype none

module linear_light_color_adjust
  import llca_pkg::*;
#(
  parameter int LINEAR_BITS      = 24,
  parameter int AMOUNT_FRAC_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                red,
  input  logic [7:0]                green,
  input  logic [7:0]                blue,
  input  logic [7:0]                alpha,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                red_out,
  output logic [7:0]                green_out,
  output logic [7:0]                blue_out,
  output logic [7:0]                alpha_out
);

  localparam int SB = LINEAR_BITS + 2;
  localparam int S3 = SB + 1;
  localparam int XL = (SB + 1) / 2;
  localparam int XH = SB - XL;
  localparam logic [SB-1:0] RECIP3 = SB'(((64'd1 << S3) + 64'd2) / 64'd3);

  logic [LINEAR_BITS-1:0] lin_tab [256];
  cfg_t                   cfg;
  cfg_t                   alpha_cfg;
  logic [LATENCY-1:0]     vld;
  logic                   advance;

  logic [7:0]             code_in [3];
  logic [LINEAR_BITS-1:0] tlin    [3];
  logic [LINEAR_BITS-1:0] lin1    [3];
  logic [LINEAR_BITS-1:0] lin2    [3];
  logic [LINEAR_BITS-1:0] lin3    [3];
  logic [LINEAR_BITS-1:0] lin4    [3];
  logic [LINEAR_BITS-1:0] res7    [3];
  logic [7:0]             code_out [3];
  logic [7:0]             a1;
  logic [7:0]             a2;
  logic [7:0]             a3;
  logic [7:0]             a4;
  logic [7:0]             a7;
  logic [7:0]             a_dly [ENC_STAGES];
  logic [SB-1:0]          sum2;
  logic [XL+SB-1:0]       pl3;
  logic [XH+SB-1:0]       ph3;
  logic [2*SB-1:0]        prod_full;
  logic [LINEAR_BITS-1:0] avg4;

  // gamma table, built at elaboration
  for (genvar k = 0; k < 256; k++) begin : g_tab
    localparam logic [63:0] ENTRY = lin_entry(k, LINEAR_BITS);
    assign lin_tab[k] = ENTRY[LINEAR_BITS-1:0];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MODE:         cfg.mode <= cfg_data[2:0];
        CFG_AMOUNT:       cfg.amount <= cfg_data[15:0];
        CFG_LERP:         cfg.lerp_fraction <= (cfg_data > LERP_ONE) ? LERP_ONE : cfg_data;
        CFG_TARGET_RED:   cfg.target_red <= cfg_data[7:0];
        CFG_TARGET_GREEN: cfg.target_green <= cfg_data[7:0];
        CFG_TARGET_BLUE:  cfg.target_blue <= cfg_data[7:0];
        CFG_TARGET_ALPHA: cfg.target_alpha <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // flow control: whole pipe holds while the output beat waits
  assign in_stall = vld[LATENCY-1] && out_stall;
  assign advance = !in_stall;
  assign out_valid = vld[LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[LATENCY-2:0], in_valid};
    end
  end

  assign code_in[0] = red;
  assign code_in[1] = green;
  assign code_in[2] = blue;
  assign tlin[0] = lin_tab[cfg.target_red];
  assign tlin[1] = lin_tab[cfg.target_green];
  assign tlin[2] = lin_tab[cfg.target_blue];

  // channel mean: sum of three, then floor divide by 3 via reciprocal in two halves
  assign prod_full = {ph3, {XL{1'b0}}} + {{(XH){1'b0}}, pl3};

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        lin1[i] <= lin_tab[code_in[i]];
        lin2[i] <= lin1[i];
        lin3[i] <= lin2[i];
        lin4[i] <= lin3[i];
      end
      a1 <= alpha;
      a2 <= a1;
      a3 <= a2;
      a4 <= a3;
      sum2 <= SB'(lin1[0]) + SB'(lin1[1]) + SB'(lin1[2]);
      pl3 <= {{SB{1'b0}}, sum2[XL-1:0]} * {{XL{1'b0}}, RECIP3};
      ph3 <= {{SB{1'b0}}, sum2[SB-1:XL]} * {{XH{1'b0}}, RECIP3};
      avg4 <= prod_full[S3 +: LINEAR_BITS];
    end
  end

  // color channels: arithmetic then re-encode
  for (genvar i = 0; i < 3; i++) begin : g_chan
    llca_channel #(
      .LINEAR_BITS      (LINEAR_BITS),
      .AMOUNT_FRAC_BITS (AMOUNT_FRAC_BITS)
    ) u_channel (
      .clk     (clk),
      .advance (advance),
      .cfg     (cfg),
      .lin     (lin4[i]),
      .avg     (avg4),
      .tgt     (tlin[i]),
      .result  (res7[i])
    );

    llca_encode #(
      .LINEAR_BITS (LINEAR_BITS)
    ) u_encode (
      .clk     (clk),
      .advance (advance),
      .lin_tab (lin_tab),
      .value   (res7[i]),
      .code    (code_out[i])
    );
  end

  // alpha interpolates on its codes, otherwise passes through
  always_comb begin
    alpha_cfg = cfg;
    alpha_cfg.mode = (cfg.mode == MODE_INTERPOLATE) ? MODE_INTERPOLATE : MODE_BYPASS;
  end

  llca_channel #(
    .LINEAR_BITS      (8),
    .AMOUNT_FRAC_BITS (AMOUNT_FRAC_BITS)
  ) u_alpha (
    .clk     (clk),
    .advance (advance),
    .cfg     (alpha_cfg),
    .lin     (a4),
    .avg     (8'd0),
    .tgt     (cfg.target_alpha),
    .result  (a7)
  );

  // alpha delay to match the encoder
  always_ff @(posedge clk) begin
    if (advance) begin
      a_dly[0] <= a7;
      for (int st = 1; st < ENC_STAGES; st++) a_dly[st] <= a_dly[st-1];
    end
  end

  assign red_out = code_out[0];
  assign green_out = code_out[1];
  assign blue_out = code_out[2];
  assign alpha_out = a_dly[ENC_STAGES-1];

endmodule

`default_nettype wire

FILE: hdl/llca_checker.sv
// llca_checker: port-level assertions for the color adjust block, bound to the top level
`default_nettype none

module llca_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out,
  input logic [7:0] alpha_out
);

  // input only waits behind a held output beat
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held output beat");

  // a free output never blocks the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while output is free");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output beat present after reset");

  // held beat stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(red_out) && $stable(green_out)
      && $stable(blue_out) && $stable(alpha_out)))
    else $error("stalled output beat changed");

endmodule

bind linear_light_color_adjust llca_checker u_llca_checker (.*);

`default_nettype wire
